FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/e2c_pkg.sv
package e2c_pkg;

   // Subtraction phases, shared by controller and datapath
   localparam logic [2:0] PH_YEAR   = 3'd0;
   localparam logic [2:0] PH_MONTH  = 3'd1;
   localparam logic [2:0] PH_DAY    = 3'd2;
   localparam logic [2:0] PH_HOUR   = 3'd3;
   localparam logic [2:0] PH_MINUTE = 3'd4;

   localparam logic [31:0] SECS_PER_MIN  = 32'd60;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
   localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
   localparam logic [2:0]  EPOCH_WEEKDAY = 3'd1;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;
   localparam logic [3:0]  FEB_INDEX     = 4'd1;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       capture;
      logic [2:0] phase;
   } e2c_cmd_type;

   typedef struct packed {
      logic fits;
      logic month_last;
   } e2c_status_type;

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] d;
      case (month)
         FEB_INDEX:                d = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:  d = 5'd30;
         default:                  d = 5'd31;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] days_to_secs(input logic [4:0] days);
      logic [31:0] s;
      case (days)
         5'd28:   s = 32'd2419200;
         5'd29:   s = 32'd2505600;
         5'd30:   s = 32'd2592000;
         default: s = 32'd2678400;
      endcase
      return s;
   endfunction

   // (a + b) mod 7 for a < 7, b < 7
   function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
         s = s - 4'd7;
      end
      return s[2:0];
   endfunction

endpackage

FILE: src/e2c_ctrl.sv
module e2c_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  e2c_pkg::e2c_status_type status,
   output e2c_pkg::e2c_cmd_type    cmd
);
   import e2c_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_YEAR   = 3'd1;
   localparam logic [2:0] S_MONTH  = 3'd2;
   localparam logic [2:0] S_DAY    = 3'd3;
   localparam logic [2:0] S_HOUR   = 3'd4;
   localparam logic [2:0] S_MINUTE = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.capture = 1'b0;
      cmd.phase   = PH_YEAR;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            cmd.phase = PH_YEAR;
            if (status.fits) cmd.step = 1'b1;
            else state_in = S_MONTH;
         end
         S_MONTH: begin
            cmd.phase = PH_MONTH;
            if (status.fits && !status.month_last) cmd.step = 1'b1;
            else state_in = S_DAY;
         end
         S_DAY: begin
            cmd.phase = PH_DAY;
            if (status.fits) cmd.step = 1'b1;
            else state_in = S_HOUR;
         end
         S_HOUR: begin
            cmd.phase = PH_HOUR;
            if (status.fits) cmd.step = 1'b1;
            else state_in = S_MINUTE;
         end
         S_MINUTE: begin
            cmd.phase = PH_MINUTE;
            if (status.fits) cmd.step = 1'b1;
            else state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (slot_free) begin
               cmd.capture = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.capture) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/e2c_datapath.sv
module e2c_datapath (
   input  logic                    clock,
   input  logic [31:0]             req_epoch_seconds,
   input  e2c_pkg::e2c_cmd_type    cmd,
   output e2c_pkg::e2c_status_type status,
   output logic [7:0]              rsp_year_offset,
   output logic [3:0]              rsp_month_index,
   output logic [4:0]              rsp_day_of_month,
   output logic [4:0]              rsp_hour_of_day,
   output logic [5:0]              rsp_minute_of_hour,
   output logic [5:0]              rsp_second_of_minute,
   output logic [2:0]              rsp_weekday,
   output logic [8:0]              rsp_day_of_year
);
   import e2c_pkg::*;

   logic [31:0] secs_ff, secs_in;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  mday_ff, mday_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [2:0]  wday_ff, wday_in;
   logic [8:0]  yday_ff, yday_in;

   logic [7:0]  out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_mday_ff;
   logic [4:0]  out_hour_ff;
   logic [5:0]  out_min_ff;
   logic [5:0]  out_sec_ff;
   logic [2:0]  out_wday_ff;
   logic [8:0]  out_yday_ff;

   logic        leap;
   logic [4:0]  mdays;
   logic [31:0] sub;
   logic [2:0]  wday_add;

   // 1900 is not a leap year
   assign leap  = (year_ff[1:0] == 2'd0) && (year_ff != 8'd0);
   assign mdays = month_days(month_ff, leap);

   always_comb begin
      case (cmd.phase)
         PH_YEAR: begin
            sub      = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            wday_add = leap ? 3'd2 : 3'd1;
         end
         PH_MONTH: begin
            sub      = days_to_secs(mdays);
            wday_add = 3'(mdays - 5'd28);   // month length mod 7
         end
         PH_DAY: begin
            sub      = SECS_PER_DAY;
            wday_add = 3'd1;
         end
         PH_HOUR: begin
            sub      = SECS_PER_HOUR;
            wday_add = 3'd0;
         end
         default: begin
            sub      = SECS_PER_MIN;
            wday_add = 3'd0;
         end
      endcase
   end

   assign status.fits       = (secs_ff >= sub);
   assign status.month_last = (month_ff >= LAST_MONTH);

   always_comb begin
      secs_in  = secs_ff;
      year_in  = year_ff;
      month_in = month_ff;
      mday_in  = mday_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      wday_in  = wday_ff;
      yday_in  = yday_ff;
      if (cmd.load) begin
         secs_in  = req_epoch_seconds;
         year_in  = '0;
         month_in = '0;
         mday_in  = '0;
         hour_in  = '0;
         min_in   = '0;
         wday_in  = EPOCH_WEEKDAY;
         yday_in  = '0;
      end else if (cmd.step) begin
         secs_in = secs_ff - sub;
         wday_in = add_mod7(wday_ff, wday_add);
         case (cmd.phase)
            PH_YEAR:  year_in = year_ff + 8'd1;
            PH_MONTH: begin
               month_in = month_ff + 4'd1;
               yday_in  = yday_ff + {4'd0, mdays};
            end
            PH_DAY: begin
               mday_in = mday_ff + 5'd1;
               yday_in = yday_ff + 9'd1;
            end
            PH_HOUR:  hour_in = hour_ff + 5'd1;
            default:  min_in  = min_ff + 6'd1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      secs_ff  <= secs_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      mday_ff  <= mday_in;
      hour_ff  <= hour_in;
      min_ff   <= min_in;
      wday_ff  <= wday_in;
      yday_ff  <= yday_in;
      if (cmd.capture) begin
         out_year_ff  <= year_ff;
         out_month_ff <= month_ff;
         out_mday_ff  <= mday_ff + 5'd1;
         out_hour_ff  <= hour_ff;
         out_min_ff   <= min_ff;
         out_sec_ff   <= secs_ff[5:0];
         out_wday_ff  <= wday_ff;
         out_yday_ff  <= yday_ff;
      end
   end

   assign rsp_year_offset      = out_year_ff;
   assign rsp_month_index      = out_month_ff;
   assign rsp_day_of_month     = out_mday_ff;
   assign rsp_hour_of_day      = out_hour_ff;
   assign rsp_minute_of_hour   = out_min_ff;
   assign rsp_second_of_minute = out_sec_ff;
   assign rsp_weekday          = out_wday_ff;
   assign rsp_day_of_year      = out_yday_ff;

endmodule

FILE: src/epoch_seconds_to_calendar_top.sv
// channel   direction  handshake         word
// req       in         req_valid/stall   req_epoch_seconds
// rsp       out        rsp_valid/stall   year .. day_of_year (8 fields)
//
// One word at a time; a conversion is a repeated-subtraction loop: after a load
// step it removes years, then months, days, hours and minutes, one unit per step,
// with an exit step per phase and a capture step at the end.
// Synchronous reset clears the controller and the output valid.
// A result held by rsp_stall occupies the output register; the next word is
// taken meanwhile, and its capture waits until that register is free.
module epoch_seconds_to_calendar_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_year_offset,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year
);
   import e2c_pkg::*;

   e2c_cmd_type    cmd;
   e2c_status_type status;

   e2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   e2c_datapath u_datapath (
      .clock                (clock),
      .req_epoch_seconds    (req_epoch_seconds),
      .cmd                  (cmd),
      .status               (status),
      .rsp_year_offset      (rsp_year_offset),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_year      (rsp_day_of_year)
   );

endmodule

FILE: src/e2c_checker.sv
`include "assert_macros.svh"

module e2c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_epoch_seconds,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_year_offset,
   input logic [3:0]  rsp_month_index,
   input logic [4:0]  rsp_day_of_month,
   input logic [4:0]  rsp_hour_of_day,
   input logic [5:0]  rsp_minute_of_hour,
   input logic [5:0]  rsp_second_of_minute,
   input logic [2:0]  rsp_weekday,
   input logic [8:0]  rsp_day_of_year
);

   logic time_ok;
   logic date_ok;

   assign time_ok = (rsp_hour_of_day <= 5'd23) && (rsp_minute_of_hour <= 6'd59) &&
                    (rsp_second_of_minute <= 6'd59);
   assign date_ok = (rsp_month_index <= 4'd11) && (rsp_day_of_month != 5'd0) &&
                    (rsp_weekday <= 3'd6) && (rsp_day_of_year <= 9'd365) &&
                    (rsp_year_offset <= 8'd136);

   // a held result stays offered
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp word dropped while stalled")

   // a stalled request word stays offered and unchanged
   `ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_epoch_seconds), "req word changed while stalled")

   // a taken word keeps the block busy on the next cycle
   `ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy after accept")

   `ASSERT_IMPL(a_time_range, rsp_valid, time_ok, "time field out of range")

   `ASSERT_IMPL(a_date_range, rsp_valid, date_ok, "date field out of range")

endmodule

bind epoch_seconds_to_calendar_top e2c_checker u_e2c_checker (.*);

FILE: bench/epoch_seconds_to_calendar_top_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top_tb;

   localparam int SECS_DAY     = 86400;
   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_WORDS = 1430;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] mday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] wday;
      logic [8:0] yday;
   } calendar_fields_type;

   class calendar_scoreboard_type;
      calendar_fields_type expected_dates[$];
      int                  errors;
      int                  results_seen;

      static function bit is_leap(int yoff);
         return (yoff % 4 == 0) && (yoff != 0);
      endfunction

      static function int month_length(int month, bit leap);
         case (month)
            1:             return leap ? 29 : 28;
            3, 5, 8, 10:   return 30;
            default:       return 31;
         endcase
      endfunction

      // Peel off years, then months, then divide out the rest.
      static function calendar_fields_type split_seconds(logic [31:0] secs);
         calendar_fields_type f;
         longint unsigned     rem;
         int                  yr, mo, yday, days, ylen, mlen, md, hr, mi;
         bit                  leap;
         rem  = secs;
         yr   = 0;
         days = 0;
         ylen = 365 + (is_leap(yr) ? 1 : 0);
         while (rem >= longint'(ylen) * SECS_DAY) begin
            rem  -= longint'(ylen) * SECS_DAY;
            days += ylen;
            yr++;
            ylen = 365 + (is_leap(yr) ? 1 : 0);
         end
         leap = is_leap(yr);
         mo   = 0;
         yday = 0;
         mlen = month_length(mo, leap);
         while (mo < 11 && rem >= longint'(mlen) * SECS_DAY) begin
            rem  -= longint'(mlen) * SECS_DAY;
            days += mlen;
            yday += mlen;
            mo++;
            mlen = month_length(mo, leap);
         end
         md   = int'(rem / SECS_DAY);
         rem  -= longint'(md) * SECS_DAY;
         days += md;
         yday += md;
         hr   = int'(rem / 3600);
         rem  -= longint'(hr) * 3600;
         mi   = int'(rem / 60);
         rem  -= longint'(mi) * 60;
         f.year   = yr[7:0];
         f.month  = mo[3:0];
         f.mday   = 5'(md + 1);
         f.hour   = hr[4:0];
         f.minute = mi[5:0];
         f.second = 6'(rem);
         f.wday   = 3'((1 + days) % 7);
         f.yday   = yday[8:0];
         return f;
      endfunction

      function void note_input(logic [31:0] secs);
         expected_dates.push_back(split_seconds(secs));
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(calendar_fields_type got);
         calendar_fields_type want;
         results_seen++;
         if (expected_dates.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_dates.pop_front();
         compare_field("year_offset", want.year, got.year);
         compare_field("month_index", want.month, got.month);
         compare_field("day_of_month", want.mday, got.mday);
         compare_field("hour_of_day", want.hour, got.hour);
         compare_field("minute_of_hour", want.minute, got.minute);
         compare_field("second_of_minute", want.second, got.second);
         compare_field("weekday", want.wday, got.wday);
         compare_field("day_of_year", want.yday, got.yday);
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_year_offset;
   logic [3:0]  rsp_month_index;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;
   logic [2:0]  rsp_weekday;
   logic [8:0]  rsp_day_of_year;

   calendar_scoreboard_type sb = new();
   int                      burst_left = 0;
   int                      idle_cycles = 0;

   epoch_seconds_to_calendar_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_year_offset      (rsp_year_offset),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_year      (rsp_day_of_year)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Seconds at midnight starting day d (0-based) of month m of year offset y.
   function automatic longint start_of(int y, int m, int d);
      longint t;
      t = 0;
      for (int i = 0; i < y; i++) begin
         t += longint'(365 + (calendar_scoreboard_type::is_leap(i) ? 1 : 0)) * SECS_DAY;
      end
      for (int i = 0; i < m; i++) begin
         t += longint'(calendar_scoreboard_type::month_length(i,
                 calendar_scoreboard_type::is_leap(y))) * SECS_DAY;
      end
      return t + longint'(d) * SECS_DAY;
   endfunction

   // Mostly near month and year edges, the rest anywhere in the range.
   function automatic logic [31:0] pick_seconds();
      longint t;
      int     y, m, d, mlen;
      if ($urandom_range(0, 4) < 2) begin
         return $urandom();
      end
      y    = $urandom_range(0, 136);
      m    = $urandom_range(0, 11);
      mlen = calendar_scoreboard_type::month_length(m,
                calendar_scoreboard_type::is_leap(y));
      case ($urandom_range(0, 2))
         0:       d = 0;
         1:       d = mlen - 1;
         default: d = $urandom_range(0, mlen - 1);
      endcase
      t = start_of(y, m, d);
      case ($urandom_range(0, 3))
         0:       t -= 1;
         1:       t += 0;
         2:       t += $urandom_range(0, SECS_DAY - 1);
         default: t += SECS_DAY - 1;
      endcase
      if (t < 0 || t > 64'hFFFF_FFFF) begin
         return $urandom();
      end
      return t[31:0];
   endfunction

   task automatic offer(input logic [31:0] secs);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(secs);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      calendar_fields_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.year   = rsp_year_offset;
         got.month  = rsp_month_index;
         got.mday   = rsp_day_of_month;
         got.hour   = rsp_hour_of_day;
         got.minute = rsp_minute_of_hour;
         got.second = rsp_second_of_minute;
         got.wday   = rsp_weekday;
         got.yday   = rsp_day_of_year;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: stretches of no stall, light stall and heavy stall, plus one
   // long hold-off so the block backs up into its input.
   initial begin
      int mode, span;
      bit held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && sb.results_seen >= 200) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 400);
         repeat (span) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      logic [31:0] directed[$];
      directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                   32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h8000_0000, 32'h7FFF_FFFF};
      // 1900 is not leap: Feb 28 runs straight into Mar 1
      directed.push_back(32'(start_of(0, 1, 27) + SECS_DAY - 1));
      directed.push_back(32'(start_of(0, 2, 0)));
      directed.push_back(32'(start_of(1, 0, 0) - 1));
      directed.push_back(32'(start_of(1, 0, 0)));
      // 1904 is leap: Feb 29 and day 365
      directed.push_back(32'(start_of(4, 1, 28)));
      directed.push_back(32'(start_of(4, 2, 0) - 1));
      directed.push_back(32'(start_of(5, 0, 0) - 1));
      directed.push_back(32'(start_of(5, 0, 0)));
      directed.push_back(32'(start_of(100, 11, 30) + SECS_DAY - 1));
      directed.push_back(32'(start_of(136, 0, 0)));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) offer(directed[i]);
      repeat (RANDOM_WORDS) offer(pick_seconds());
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
